FILE: hdl/e2q_pkg.sv
// package for the euler to quaternion block: types, constants, cordic table
`default_nettype none
package e2q_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int CORDIC_STEPS   = 30;
  localparam int CORD_W         = 34;
  localparam int TRIG_W         = 32;

  typedef logic signed [CORD_W-1:0] cord_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  // sine and cosine of one half angle, q2.30
  typedef struct packed {
    trig_t sn;
    trig_t cs;
  } sincos_t;

  localparam cord_t CORDIC_GAIN = 34'sd652032874;

  // arctangent of 2^-i, 2^32 units per full turn
  function automatic cord_t atan_at(input int unsigned i);
    cord_t r;
    case (i)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      24: r = 34'sd41;
      25: r = 34'sd20;
      26: r = 34'sd10;
      27: r = 34'sd5;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/euler_to_quaternion.sv
// top level: roll, pitch and yaw to unit quaternion
// pipeline from start to out_valid: fold, 30 cordic rotation stages, unfold,
// two product stages and one rounding stage, all registered
// throughput one item per cycle; busy is always low, the receiver cannot stall
// synchronous active-low reset clears the valid bits, payload is not reset
`default_nettype none
module euler_to_quaternion
  import e2q_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_roll,
  input  wire logic [15:0] in_pitch,
  input  wire logic [15:0] in_yaw,
  output logic             out_valid,
  output logic [15:0]      out_qx,
  output logic [15:0]      out_qy,
  output logic [15:0]      out_qz,
  output logic [15:0]      out_qw
);

  logic    acc;
  logic    v_r, v_p, v_y;
  sincos_t sc_r, sc_p, sc_y;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  // three half-angle cordic lanes
  e2q_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .rst_n(rst_n), .in_vld(acc), .angle(in_roll),
    .out_vld(v_r), .res(sc_r)
  );
  e2q_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .rst_n(rst_n), .in_vld(acc), .angle(in_pitch),
    .out_vld(v_p), .res(sc_p)
  );
  e2q_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .rst_n(rst_n), .in_vld(acc), .angle(in_yaw),
    .out_vld(v_y), .res(sc_y)
  );

  // cross products
  e2q_combine #(.FRAC_BITS(FRAC_BITS)) u_comb (
    .clk(clk), .rst_n(rst_n), .in_vld(v_r & v_p & v_y),
    .r(sc_r), .p(sc_p), .y(sc_y),
    .out_vld(out_valid), .qx(out_qx), .qy(out_qy), .qz(out_qz), .qw(out_qw)
  );

endmodule
`default_nettype wire

FILE: hdl/e2q_sincos.sv
// pipelined cordic: sine and cosine of one half angle
`default_nettype none
module e2q_sincos
  import e2q_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  input  wire logic [15:0] angle,
  output logic             out_vld,
  output sincos_t          res
);

  localparam int SH = 31 - ANGLE_BITS;

  // fold stage
  logic [31:0] phase;
  logic [31:0] phase_adj;
  logic [31:0] folded;
  logic        flip;

  assign phase     = {{16{angle[15]}}, angle} << SH;
  assign phase_adj = phase + 32'h4000_0000;
  assign flip      = phase_adj[31];
  assign folded    = flip ? (phase ^ 32'h8000_0000) : phase;

  cord_t x_r [0:CORDIC_STEPS];
  cord_t y_r [0:CORDIC_STEPS];
  cord_t z_r [0:CORDIC_STEPS];
  logic  f_r [0:CORDIC_STEPS];
  logic  v_r [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_vld;
    end
    x_r[0] <= CORDIC_GAIN;
    y_r[0] <= '0;
    z_r[0] <= cord_t'($signed(folded));
    f_r[0] <= flip;
  end

  // one rotation per stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    cord_t x_nxt, y_nxt, z_nxt;
    always_comb begin
      if (!z_r[k][CORD_W-1]) begin
        x_nxt = x_r[k] - (y_r[k] >>> k);
        y_nxt = y_r[k] + (x_r[k] >>> k);
        z_nxt = z_r[k] - atan_at(k);
      end else begin
        x_nxt = x_r[k] + (y_r[k] >>> k);
        y_nxt = y_r[k] - (x_r[k] >>> k);
        z_nxt = z_r[k] + atan_at(k);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
      x_r[k+1] <= x_nxt;
      y_r[k+1] <= y_nxt;
      z_r[k+1] <= z_nxt;
      f_r[k+1] <= f_r[k];
    end
  end

  // unfold stage: undo the half-turn move
  cord_t   sn_full, cs_full;
  sincos_t res_nxt;
  sincos_t res_r;
  logic    vo_r;

  assign sn_full    = f_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
  assign cs_full    = f_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
  assign res_nxt.sn = sn_full[TRIG_W-1:0];
  assign res_nxt.cs = cs_full[TRIG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[CORDIC_STEPS];
    end
    res_r <= res_nxt;
  end

  assign out_vld = vo_r;
  assign res     = res_r;

endmodule
`default_nettype wire

FILE: hdl/e2q_combine.sv
// cross products, rounding and saturation to the quaternion
`default_nettype none
module e2q_combine
  import e2q_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  input  sincos_t          r,
  input  sincos_t          p,
  input  sincos_t          y,
  output logic             out_vld,
  output logic [15:0]      qx,
  output logic [15:0]      qy,
  output logic [15:0]      qz,
  output logic [15:0]      qw
);

  localparam int DST = 60 - FRAC_BITS;
  localparam logic signed [63:0] HALF30 = 64'sd1 <<< 29;
  localparam logic signed [65:0] HALFD  = 66'sd1 <<< (DST - 1);
  localparam logic signed [65:0] LIM    = 66'sd1 <<< FRAC_BITS;

  // stage a: pitch-yaw pair products rounded to q2.30
  logic signed [63:0] cc_w, sc_w, cs_w, ss_w;
  trig_t cc_r, sc_r, cs_r, ss_r, rs_a_r, rc_a_r;
  logic  va_r;

  assign cc_w = ((64'(p.cs) * 64'(y.cs)) + HALF30) >>> 30;
  assign sc_w = ((64'(p.sn) * 64'(y.cs)) + HALF30) >>> 30;
  assign cs_w = ((64'(p.cs) * 64'(y.sn)) + HALF30) >>> 30;
  assign ss_w = ((64'(p.sn) * 64'(y.sn)) + HALF30) >>> 30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_vld;
    end
    cc_r   <= cc_w[TRIG_W-1:0];
    sc_r   <= sc_w[TRIG_W-1:0];
    cs_r   <= cs_w[TRIG_W-1:0];
    ss_r   <= ss_w[TRIG_W-1:0];
    rs_a_r <= r.sn;
    rc_a_r <= r.cs;
  end

  // stage b: roll products
  logic signed [63:0] m_r [0:7];
  logic               vb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    m_r[0] <= 64'(rs_a_r) * 64'(cc_r);
    m_r[1] <= 64'(rc_a_r) * 64'(ss_r);
    m_r[2] <= 64'(rc_a_r) * 64'(sc_r);
    m_r[3] <= 64'(rs_a_r) * 64'(cs_r);
    m_r[4] <= 64'(rc_a_r) * 64'(cs_r);
    m_r[5] <= 64'(rs_a_r) * 64'(sc_r);
    m_r[6] <= 64'(rc_a_r) * 64'(cc_r);
    m_r[7] <= 64'(rs_a_r) * 64'(ss_r);
  end

  // round to q2.frac and saturate
  function automatic logic [15:0] finish(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + HALFD) >>> DST;
    if (t > LIM) t = LIM;
    if (t < -LIM) t = -LIM;
    return t[15:0];
  endfunction

  // stage c: sums and output register
  logic [15:0] qx_r, qy_r, qz_r, qw_r;
  logic        vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
    qx_r <= finish(66'(m_r[0]) - 66'(m_r[1]));
    qy_r <= finish(66'(m_r[2]) + 66'(m_r[3]));
    qz_r <= finish(66'(m_r[4]) - 66'(m_r[5]));
    qw_r <= finish(66'(m_r[6]) + 66'(m_r[7]));
  end

  assign out_vld = vc_r;
  assign qx      = qx_r;
  assign qy      = qy_r;
  assign qz      = qz_r;
  assign qw      = qw_r;

endmodule
`default_nettype wire

FILE: tb/sv/euler_to_quaternion_test.sv
// testbench for the euler to quaternion block: directed and random angles, scoreboarded
`default_nettype none
module euler_to_quaternion_test;
  import e2q_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANG_BITS = 16;
  localparam int FRC_BITS = 14;
  localparam int STEPS    = 30;

  typedef struct {
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] qz;
    logic [15:0] qw;
  } quat_t;

  // predictor helpers, all arithmetic on 64-bit signed values
  function automatic longint unsigned_atan(int i);
    longint t [30] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};
    return t[i];
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // sine and cosine of half the angle, q2.30
  task automatic half_trig(input logic [15:0] ang, output longint sn, output longint cs);
    logic [31:0] ph;
    logic flip;
    longint x, y, z, nx;
    ph = {{16{ang[15]}}, ang} << (31 - ANG_BITS);
    flip = ph[31] ^ ph[30];
    if (flip) ph = ph - 32'h8000_0000;
    z = longint'(signed'(ph));
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - unsigned_atan(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + unsigned_atan(i);
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  function automatic logic [15:0] to_q14(longint q60);
    longint v, lim;
    v = rnd_shift(q60, 60 - FRC_BITS);
    lim = longint'(1) <<< FRC_BITS;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  task automatic predict_quat(input logic [15:0] r, p, yw, output quat_t q);
    longint rs, rc, ps, pc, ys, yc, cc, sc, cs, ss;
    half_trig(r, rs, rc);
    half_trig(p, ps, pc);
    half_trig(yw, ys, yc);
    cc = rnd_shift(pc * yc, 30);
    sc = rnd_shift(ps * yc, 30);
    cs = rnd_shift(pc * ys, 30);
    ss = rnd_shift(ps * ys, 30);
    q.qx = to_q14(rs * cc - rc * ss);
    q.qy = to_q14(rc * sc + rs * cs);
    q.qz = to_q14(rc * cs - rs * sc);
    q.qw = to_q14(rc * cc + rs * ss);
  endtask

  int errors = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // scoreboard of expected quaternions
  class quat_board;
    quat_t pending[$];
    task note_item(logic [15:0] r, p, yw);
      quat_t q;
      predict_quat(r, p, yw, q);
      pending.push_back(q);
    endtask
    task check_result(logic [15:0] x, y, z, w);
      quat_t e;
      if (pending.size() == 0) begin
        report("result with no item pending");
        return;
      end
      e = pending.pop_front();
      if (x !== e.qx) report($sformatf("qx got %h want %h", x, e.qx));
      if (y !== e.qy) report($sformatf("qy got %h want %h", y, e.qy));
      if (z !== e.qz) report($sformatf("qz got %h want %h", z, e.qz));
      if (w !== e.qw) report($sformatf("qw got %h want %h", w, e.qw));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [15:0] in_roll = 0, in_pitch = 0, in_yaw = 0;
  logic out_valid;
  logic [15:0] out_qx, out_qy, out_qz, out_qw;
  quat_board board = new();

  always #2 clk = ~clk;

  euler_to_quaternion dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_roll(in_roll), .in_pitch(in_pitch), .in_yaw(in_yaw),
    .out_valid(out_valid), .out_qx(out_qx), .out_qy(out_qy),
    .out_qz(out_qz), .out_qw(out_qw)
  );

  // sample results and accepted items at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) board.check_result(out_qx, out_qy, out_qz, out_qw);
      if (start && !busy) board.note_item(in_roll, in_pitch, in_yaw);
    end
  end

  // present one item, optionally idling first, and wait until accepted
  task automatic send_item(input logic [15:0] r, p, yw, input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1;
    in_roll <= r;
    in_pitch <= p;
    in_yaw <= yw;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(signed'($urandom_range(0, 64)) - 32);
      3: return {2'($urandom_range(0, 3)), 14'h0} + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] edges [8] = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000,
                              16'hc000, 16'h0001, 16'hffff, 16'h2000};
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extreme and quadrant angles on each axis, wraps, all zero
    foreach (edges[i]) send_item(edges[i], 16'h0, 16'h0, 0);
    foreach (edges[i]) send_item(16'h0, edges[i], 16'h0, 0);
    foreach (edges[i]) send_item(16'h0, 16'h0, edges[i], 0);
    send_item(16'h7fff, 16'h8000, 16'h7fff, 0);
    // sender holds off until the pipeline drains
    start <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    // random with idle bursts, then back to back
    for (int n = 0; n < 1500; n++)
      send_item(rand_angle(), rand_angle(), rand_angle(), n < 1200);
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
